// File: rtl/pbgc_pkg.sv
package pbgc_pkg;

    localparam int DIST_W  = 11;
    localparam int LEN_W   = 9;
    localparam int MODE_W  = 2;
    localparam int STEP_W  = 4;
    localparam int CNT4_W  = 4;
    localparam int DISP_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 9;

    // shared multiply/divide unit
    localparam int MUL_W   = 10;
    localparam int DIV_W   = 2 * MUL_W;
    localparam int DVS_W   = 10;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic [MUL_W-1:0] SCALE = 10'd1000;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MIN_DISTANCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAPPING_MODE = 3'd2;
    localparam logic [IDX_W-1:0] REG_STRIP_LENGTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_RAMP_STEPS   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ERROR_LIMIT  = 3'd5;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_MIN_DISTANCE = 9'd1;
    localparam logic [LEN_W-1:0]  RST_MAX_DISTANCE = 9'd100;
    localparam logic [MODE_W-1:0] RST_MAPPING_MODE = 2'd0;
    localparam logic [LEN_W-1:0]  RST_STRIP_LENGTH = 9'd144;
    localparam logic [STEP_W-1:0] RST_RAMP_STEPS   = 4'd5;
    localparam logic [CNT4_W-1:0] RST_ERROR_LIMIT  = 4'd3;

    // mapping modes
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZONES   = 2'd2;

    // display states
    localparam logic [DISP_W-1:0] DISP_BAR        = 2'd0;
    localparam logic [DISP_W-1:0] DISP_BLINK_LIT  = 2'd1;
    localparam logic [DISP_W-1:0] DISP_BLINK_DARK = 2'd2;
    localparam logic [DISP_W-1:0] DISP_BLANK      = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0]  min_distance;
        logic [LEN_W-1:0]  max_distance;
        logic [MODE_W-1:0] mapping_mode;
        logic [LEN_W-1:0]  strip_length;
        logic [STEP_W-1:0] ramp_steps;
        logic [CNT4_W-1:0] error_limit;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [MUL_W-1:0]  mul_a;
        logic [MUL_W-1:0]  mul_b;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

    typedef struct packed {
        logic [LEN_W-1:0]  bar_length;
        logic              ramping;
        logic [DISP_W-1:0] display_state;
    } t_result;

endpackage

// File: rtl/proximity_bar_graph_controller_unit.sv
// proximity bar graph controller: one distance reading in, one display result out.
// input channel: i_valid/o_ready with i_distance_cm (signed cm; zero or less, or
// above max_distance, is a failed reading). output channel: o_valid/i_ready with
// o_bar_length, o_ramping and o_display_state. registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the block is
// idle, the block itself does not enforce this.
// a blink or blank result passes from the sequencer's result register to the output
// register; a bar result first runs through one shared multiply and restoring
// divide unit: up to three divides for the mapping (normalize, square, scale to the
// strip) and two for the ramp step.
// one request is processed at a time; o_ready is high only while the sequencer
// is idle. results go to an output register, so a new request is taken while a
// finished result still waits; if the receiver stalls further, the sequencer
// holds its next result until the output register frees up.
// reset clears the registers to their defaults, the error count, held reading,
// target, shown bar, ramp position and blink phase.
module proximity_bar_graph_controller_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pbgc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [pbgc_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pbgc_pkg::DIST_W-1:0]   i_distance_cm,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [pbgc_pkg::LEN_W-1:0]           o_bar_length,
    output logic                                 o_ramping,
    output logic [pbgc_pkg::DISP_W-1:0]          o_display_state
);

    pbgc_pkg::t_cfg     r_cfg, n_cfg;
    pbgc_pkg::t_div_req div_req;
    pbgc_pkg::t_div_rsp div_rsp;
    pbgc_pkg::t_result  core_res;
    pbgc_pkg::t_result  r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               core_valid;
    logic               slot_free;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbgc_pkg::REG_MIN_DISTANCE: n_cfg.min_distance = i_cfg_data;
                pbgc_pkg::REG_MAX_DISTANCE: n_cfg.max_distance = i_cfg_data;
                pbgc_pkg::REG_MAPPING_MODE:
                    n_cfg.mapping_mode = i_cfg_data[pbgc_pkg::MODE_W-1:0];
                pbgc_pkg::REG_STRIP_LENGTH: n_cfg.strip_length = i_cfg_data;
                pbgc_pkg::REG_RAMP_STEPS:
                    n_cfg.ramp_steps = i_cfg_data[pbgc_pkg::STEP_W-1:0];
                pbgc_pkg::REG_ERROR_LIMIT:
                    n_cfg.error_limit = i_cfg_data[pbgc_pkg::CNT4_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_ready) n_out_valid = 1'b0;
        if (core_valid && slot_free) begin
            n_out_valid = 1'b1;
            n_out       = core_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance <= pbgc_pkg::RST_MIN_DISTANCE;
            r_cfg.max_distance <= pbgc_pkg::RST_MAX_DISTANCE;
            r_cfg.mapping_mode <= pbgc_pkg::RST_MAPPING_MODE;
            r_cfg.strip_length <= pbgc_pkg::RST_STRIP_LENGTH;
            r_cfg.ramp_steps   <= pbgc_pkg::RST_RAMP_STEPS;
            r_cfg.error_limit  <= pbgc_pkg::RST_ERROR_LIMIT;
            r_out_valid        <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    pbgc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pbgc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_valid),
        .o_in_ready    (o_ready),
        .i_distance_cm (i_distance_cm),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_res_valid   (core_valid),
        .o_res         (core_res),
        .i_res_ready   (slot_free)
    );

    assign o_valid         = r_out_valid;
    assign o_bar_length    = r_out.bar_length;
    assign o_ramping       = r_out.ramping;
    assign o_display_state = r_out.display_state;

endmodule

// File: rtl/pbgc_muldiv.sv
module pbgc_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbgc_pkg::t_div_req i_req,
    output pbgc_pkg::t_div_rsp o_rsp
);

    localparam int DIV_W  = pbgc_pkg::DIV_W;
    localparam int DVS_W  = pbgc_pkg::DVS_W;
    localparam int DCNT_W = pbgc_pkg::DCNT_W;
    localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(DIV_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_dvd, n_dvd;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = DIV_W'(i_req.mul_a) * DIV_W'(i_req.mul_b);
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_dvd = {r_dvd[DIV_W-2:0], fits};
            n_cnt = r_cnt + DCNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

// File: rtl/pbgc_core.sv
module pbgc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pbgc_pkg::t_cfg                      i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [pbgc_pkg::DIST_W-1:0]  i_distance_cm,
    output pbgc_pkg::t_div_req                  o_div_req,
    input  pbgc_pkg::t_div_rsp                  i_div_rsp,
    output logic                                o_res_valid,
    output pbgc_pkg::t_result                   o_res,
    input  logic                                i_res_ready
);

    localparam int LEN_W  = pbgc_pkg::LEN_W;
    localparam int MUL_W  = pbgc_pkg::MUL_W;
    localparam int DVS_W  = pbgc_pkg::DVS_W;
    localparam int CNT_W  = pbgc_pkg::CNT4_W;
    localparam int STEP_W = pbgc_pkg::STEP_W;
    localparam int QA_W   = 13;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_MAP  = 4'd1;
    localparam logic [ST_W-1:0] ST_NORM = 4'd2;
    localparam logic [ST_W-1:0] ST_SQ   = 4'd3;
    localparam logic [ST_W-1:0] ST_LEN  = 4'd4;
    localparam logic [ST_W-1:0] ST_TGT  = 4'd5;
    localparam logic [ST_W-1:0] ST_CHK  = 4'd6;
    localparam logic [ST_W-1:0] ST_RA   = 4'd7;
    localparam logic [ST_W-1:0] ST_RB   = 4'd8;
    localparam logic [ST_W-1:0] ST_FIN  = 4'd9;
    localparam logic [ST_W-1:0] ST_OUT  = 4'd10;

    function automatic logic [MUL_W-1:0] zone_value(input logic [MUL_W-1:0] norm);
        logic [MUL_W-1:0] v;
        if (norm > 10'd800)      v = 10'd1000;
        else if (norm > 10'd600) v = 10'd750;
        else if (norm > 10'd400) v = 10'd500;
        else if (norm > 10'd200) v = 10'd250;
        else                     v = 10'd100;
        return v;
    endfunction

    logic [ST_W-1:0]   r_state, n_state;
    logic [CNT_W-1:0]  r_bad_cnt, n_bad_cnt;
    logic [LEN_W-1:0]  r_held, n_held;
    logic              r_held_ok, n_held_ok;
    logic [LEN_W-1:0]  r_target, n_target;
    logic [LEN_W-1:0]  r_shown, n_shown;
    logic [STEP_W-1:0] r_pos, n_pos;
    logic              r_blink, n_blink;
    logic [LEN_W-1:0]  r_dist, n_dist;
    logic [LEN_W-1:0]  r_newt, n_newt;
    logic              r_neg, n_neg;
    logic [LEN_W-1:0]  r_mag, n_mag;
    logic [QA_W-1:0]   r_qa, n_qa;
    pbgc_pkg::t_result r_res, n_res;

    logic              d_ok;
    logic [CNT_W-1:0]  cnt_inc;
    logic [MUL_W-1:0]  quo10;
    logic [MUL_W-1:0]  sq_val;
    logic [LEN_W-1:0]  inc9;
    logic [QA_W-1:0]   inc;

    assign d_ok = !i_distance_cm[pbgc_pkg::DIST_W-1] && (i_distance_cm != '0)
                  && (i_distance_cm[MUL_W-1:0] <= {1'b0, i_cfg.max_distance});
    assign cnt_inc = (r_bad_cnt < i_cfg.error_limit) ? r_bad_cnt + CNT_W'(1) : r_bad_cnt;
    assign quo10   = i_div_rsp.quotient[MUL_W-1:0];
    assign sq_val  = quo10;
    assign inc     = r_qa - i_div_rsp.quotient[QA_W-1:0];
    assign inc9    = inc[LEN_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_bad_cnt = r_bad_cnt;
        n_held    = r_held;
        n_held_ok = r_held_ok;
        n_target  = r_target;
        n_shown   = r_shown;
        n_pos     = r_pos;
        n_blink   = r_blink;
        n_dist    = r_dist;
        n_newt    = r_newt;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_qa      = r_qa;
        n_res     = r_res;
        o_div_req = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (d_ok) begin
                        n_bad_cnt = '0;
                        n_held    = i_distance_cm[LEN_W-1:0];
                        n_held_ok = 1'b1;
                        n_dist    = i_distance_cm[LEN_W-1:0];
                        n_state   = ST_MAP;
                    end else begin
                        n_bad_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.error_limit) begin
                            n_blink = !r_blink;
                            n_res.bar_length    = '0;
                            n_res.ramping       = 1'b0;
                            n_res.display_state = !r_blink ? pbgc_pkg::DISP_BLINK_LIT
                                                           : pbgc_pkg::DISP_BLINK_DARK;
                            n_state = ST_OUT;
                        end else if (r_held_ok) begin
                            n_dist  = r_held;
                            n_state = ST_MAP;
                        end else begin
                            n_res.bar_length    = '0;
                            n_res.ramping       = 1'b0;
                            n_res.display_state = pbgc_pkg::DISP_BLANK;
                            n_state = ST_OUT;
                        end
                    end
                end
            end
            ST_MAP: begin
                // empty range or a reading (new or held) outside the current range maps to zero
                if (i_cfg.max_distance <= i_cfg.min_distance
                    || r_dist < i_cfg.min_distance || r_dist > i_cfg.max_distance) begin
                    n_newt  = '0;
                    n_state = ST_TGT;
                end else begin
                    o_div_req.start   = 1'b1;
                    o_div_req.mul_a   = pbgc_pkg::SCALE;
                    o_div_req.mul_b   = {1'b0, i_cfg.max_distance - r_dist};
                    o_div_req.divisor = {1'b0, i_cfg.max_distance - i_cfg.min_distance};
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_div_rsp.done) begin
                    o_div_req.mul_b   = {1'b0, i_cfg.strip_length};
                    o_div_req.divisor = pbgc_pkg::SCALE;
                    case (i_cfg.mapping_mode)
                        pbgc_pkg::MODE_LINEAR: begin
                            o_div_req.start = 1'b1;
                            o_div_req.mul_a = quo10;
                            n_state = ST_LEN;
                        end
                        pbgc_pkg::MODE_SQUARED: begin
                            o_div_req.start = 1'b1;
                            o_div_req.mul_a = quo10;
                            o_div_req.mul_b = quo10;
                            n_state = ST_SQ;
                        end
                        pbgc_pkg::MODE_ZONES: begin
                            o_div_req.start = 1'b1;
                            o_div_req.mul_a = zone_value(quo10);
                            n_state = ST_LEN;
                        end
                        default: begin
                            n_newt  = '0;
                            n_state = ST_TGT;
                        end
                    endcase
                end
            end
            ST_SQ: begin
                if (i_div_rsp.done) begin
                    o_div_req.start   = 1'b1;
                    o_div_req.mul_a   = sq_val;
                    o_div_req.mul_b   = {1'b0, i_cfg.strip_length};
                    o_div_req.divisor = pbgc_pkg::SCALE;
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (i_div_rsp.done) begin
                    n_newt  = (quo10 > {1'b0, i_cfg.strip_length}) ? i_cfg.strip_length
                                                                   : quo10[LEN_W-1:0];
                    n_state = ST_TGT;
                end
            end
            ST_TGT: begin
                if (r_newt != r_target) begin
                    n_target = r_newt;
                    n_pos    = '0;
                end
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_shown != r_target) begin
                    if (r_pos < i_cfg.ramp_steps) begin
                        n_neg = r_target < r_shown;
                        n_mag = (r_target < r_shown) ? r_shown - r_target
                                                     : r_target - r_shown;
                        o_div_req.start   = 1'b1;
                        o_div_req.mul_a   = {1'b0, n_mag};
                        o_div_req.mul_b   = {{(MUL_W-STEP_W){1'b0}}, r_pos} + MUL_W'(1);
                        o_div_req.divisor = {{(DVS_W-STEP_W){1'b0}}, i_cfg.ramp_steps};
                        n_state = ST_RA;
                    end else begin
                        n_shown = r_target;
                        n_state = ST_FIN;
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_RA: begin
                if (i_div_rsp.done) begin
                    n_qa = i_div_rsp.quotient[QA_W-1:0];
                    o_div_req.start   = 1'b1;
                    o_div_req.mul_a   = {1'b0, r_mag};
                    o_div_req.mul_b   = {{(MUL_W-STEP_W){1'b0}}, r_pos};
                    o_div_req.divisor = {{(DVS_W-STEP_W){1'b0}}, i_cfg.ramp_steps};
                    n_state = ST_RB;
                end
            end
            ST_RB: begin
                // magnitudes divide toward zero, the sign is applied afterwards
                if (i_div_rsp.done) begin
                    n_shown = r_neg ? r_shown - inc9 : r_shown + inc9;
                    n_pos   = r_pos + STEP_W'(1);
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_res.bar_length    = (r_shown > i_cfg.strip_length) ? i_cfg.strip_length
                                                                     : r_shown;
                n_res.ramping       = r_shown != r_target;
                n_res.display_state = pbgc_pkg::DISP_BAR;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bad_cnt <= '0;
            r_held_ok <= 1'b0;
            r_target  <= '0;
            r_shown   <= '0;
            r_pos     <= '0;
            r_blink   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bad_cnt <= n_bad_cnt;
            r_held_ok <= n_held_ok;
            r_target  <= n_target;
            r_shown   <= n_shown;
            r_pos     <= n_pos;
            r_blink   <= n_blink;
        end
        r_held <= n_held;
        r_dist <= n_dist;
        r_newt <= n_newt;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_qa   <= n_qa;
        r_res  <= n_res;
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_res_valid = r_state == ST_OUT;
    assign o_res       = r_res;

endmodule

// File: verif/proximity_bar_graph_controller_unit_tb.sv
`timescale 1ns / 100ps

module proximity_bar_graph_controller_unit_tb;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 150;
    localparam int REPORT_LIMIT    = 200;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [pbgc_pkg::IDX_W-1:0]          i_cfg_idx = '0;
    logic [pbgc_pkg::DATA_W-1:0]         i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [pbgc_pkg::DIST_W-1:0]  i_distance_cm = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [pbgc_pkg::LEN_W-1:0]          o_bar_length;
    logic                                o_ramping;
    logic [pbgc_pkg::DISP_W-1:0]         o_display_state;

    proximity_bar_graph_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_distance_cm   (i_distance_cm),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bar_length    (o_bar_length),
        .o_ramping       (o_ramping),
        .o_display_state (o_display_state)
    );

    // register copy and display state mirrored from the block
    pbgc_pkg::t_cfg display_cfg = '{pbgc_pkg::RST_MIN_DISTANCE, pbgc_pkg::RST_MAX_DISTANCE,
                                    pbgc_pkg::RST_MAPPING_MODE, pbgc_pkg::RST_STRIP_LENGTH,
                                    pbgc_pkg::RST_RAMP_STEPS, pbgc_pkg::RST_ERROR_LIMIT};
    logic [pbgc_pkg::CNT4_W-1:0] bad_count = '0;
    int                          held_reading = -1;
    logic [pbgc_pkg::LEN_W-1:0]  target_len = '0;
    logic [pbgc_pkg::LEN_W-1:0]  shown_len = '0;
    logic [pbgc_pkg::STEP_W-1:0] ramp_pos = '0;
    logic                        blink_lit = 1'b0;

    logic signed [pbgc_pkg::DIST_W-1:0] reading_queue[$];
    pbgc_pkg::t_result                  pending_display[$];

    int idle_pct = 31;
    int mismatch_count = 0;
    int stall_cycles = 0;
    bit hold_off_req = 1'b0;
    bit hold_off_started = 1'b0;
    int hold_off_left = 0;
    pbgc_pkg::t_result got_display;
    pbgc_pkg::t_result want_display;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int bar_target(input int d);
        int lo, hi, strip, norm, level, len;
        lo = display_cfg.min_distance;
        hi = display_cfg.max_distance;
        strip = display_cfg.strip_length;
        if (hi <= lo || d < lo || d > hi) begin
            return 0;
        end
        norm = 1000 * (hi - d) / (hi - lo);
        case (display_cfg.mapping_mode)
            pbgc_pkg::MODE_LINEAR:  level = norm;
            pbgc_pkg::MODE_SQUARED: level = norm * norm / 1000;
            pbgc_pkg::MODE_ZONES: begin
                if (norm > 800)      level = 1000;
                else if (norm > 600) level = 750;
                else if (norm > 400) level = 500;
                else if (norm > 200) level = 250;
                else                 level = 100;
            end
            default: level = 0;
        endcase
        len = level * strip / 1000;
        return (len > strip) ? strip : len;
    endfunction

    function automatic pbgc_pkg::t_result advance_display(
        input logic signed [pbgc_pkg::DIST_W-1:0] reading);
        int d, newt, diff, s, p, inc;
        pbgc_pkg::t_result r;
        d = reading;
        r = '0;
        if (!(d > 0 && d <= int'(display_cfg.max_distance))) begin
            if (bad_count < display_cfg.error_limit) bad_count = bad_count + 1'b1;
            if (bad_count >= display_cfg.error_limit) begin
                blink_lit = ~blink_lit;
                r.display_state = blink_lit ? pbgc_pkg::DISP_BLINK_LIT
                                            : pbgc_pkg::DISP_BLINK_DARK;
                return r;
            end
            if (held_reading > 0) begin
                d = held_reading;
            end else begin
                r.display_state = pbgc_pkg::DISP_BLANK;
                return r;
            end
        end else begin
            bad_count = '0;
            held_reading = d;
        end

        newt = bar_target(d);
        if (newt != int'(target_len)) begin
            target_len = pbgc_pkg::LEN_W'(newt);
            ramp_pos = '0;
        end
        if (shown_len != target_len) begin
            if (ramp_pos < display_cfg.ramp_steps) begin
                diff = int'(target_len) - int'(shown_len);
                s = display_cfg.ramp_steps;
                p = ramp_pos;
                // signed step, truncating toward zero
                inc = diff * (p + 1) / s - diff * p / s;
                shown_len = pbgc_pkg::LEN_W'(int'(shown_len) + inc);
                ramp_pos = ramp_pos + 1'b1;
            end else begin
                shown_len = target_len;
            end
        end
        r.bar_length = (shown_len > display_cfg.strip_length) ? display_cfg.strip_length
                                                              : shown_len;
        r.ramping = (shown_len != target_len);
        r.display_state = pbgc_pkg::DISP_BAR;
        return r;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [pbgc_pkg::LEN_W-1:0] want,
                                          input logic [pbgc_pkg::LEN_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pending_display.push_back(advance_display(i_distance_cm));
            end
            if (!i_valid || o_ready) begin
                if (reading_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid <= 1'b1;
                    i_distance_cm <= reading_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got_display = '{o_bar_length, o_ramping, o_display_state};
                if (pending_display.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, o_bar_length, o_ramping, o_display_state);
                end else begin
                    want_display = pending_display.pop_front();
                    compare_field("bar_length", want_display.bar_length,
                                  got_display.bar_length);
                    compare_field("ramping", pbgc_pkg::LEN_W'(want_display.ramping),
                                  pbgc_pkg::LEN_W'(got_display.ramping));
                    compare_field("display_state",
                                  pbgc_pkg::LEN_W'(want_display.display_state),
                                  pbgc_pkg::LEN_W'(got_display.display_state));
                end
            end
            if (hold_off_req && !hold_off_started) begin
                hold_off_started = 1'b1;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (reading_queue.size() != 0 || i_valid || pending_display.size() != 0) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_reading(input int d);
        reading_queue.push_back(pbgc_pkg::DIST_W'(d));
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (reading_queue.size() != 0 || i_valid || pending_display.size() != 0);
    endtask

    task automatic write_reg(input logic [pbgc_pkg::IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= pbgc_pkg::DATA_W'(value);
        case (idx)
            pbgc_pkg::REG_MIN_DISTANCE:
                display_cfg.min_distance = pbgc_pkg::LEN_W'(value);
            pbgc_pkg::REG_MAX_DISTANCE:
                display_cfg.max_distance = pbgc_pkg::LEN_W'(value);
            pbgc_pkg::REG_MAPPING_MODE:
                display_cfg.mapping_mode = pbgc_pkg::MODE_W'(value);
            pbgc_pkg::REG_STRIP_LENGTH:
                display_cfg.strip_length = pbgc_pkg::LEN_W'(value);
            pbgc_pkg::REG_RAMP_STEPS:
                display_cfg.ramp_steps = pbgc_pkg::STEP_W'(value);
            pbgc_pkg::REG_ERROR_LIMIT:
                display_cfg.error_limit = pbgc_pkg::CNT4_W'(value);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int min_d, input int max_d, input int mode,
                                  input int strip, input int steps, input int limit);
        wait_idle();
        write_reg(pbgc_pkg::REG_MIN_DISTANCE, min_d);
        write_reg(pbgc_pkg::REG_MAX_DISTANCE, max_d);
        write_reg(pbgc_pkg::REG_MAPPING_MODE, mode);
        write_reg(pbgc_pkg::REG_STRIP_LENGTH, strip);
        write_reg(pbgc_pkg::REG_RAMP_STEPS, steps);
        write_reg(pbgc_pkg::REG_ERROR_LIMIT, limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_settings();
        int min_d, max_d;
        min_d = $urandom_range(399, 1);
        max_d = $urandom_range(400, min_d + 1);
        apply_settings(min_d, max_d, $urandom_range(2, 0), $urandom_range(500, 1),
                       $urandom_range(15, 1), $urandom_range(15, 1));
    endtask

    // mostly dwells on one distance so the ramp can settle, plus runs of failed
    // readings around the error limit, range edges and raw noise
    task automatic queue_traffic(input int n);
        int made, reps, d, lo, hi, roll;
        made = 0;
        hi = display_cfg.max_distance;
        lo = display_cfg.min_distance;
        if (hi < 1) hi = 1;
        if (lo < 1 || lo > hi) lo = 1;
        while (made < n) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                d = $urandom_range(hi, lo);
                reps = $urandom_range(display_cfg.ramp_steps + 3, 1);
                repeat (reps) begin
                    push_reading(($urandom_range(3) == 0 && d < hi) ? d + 1 : d);
                    made++;
                end
            end else if (roll < 78) begin
                reps = $urandom_range(display_cfg.error_limit + 2, 1);
                repeat (reps) begin
                    case ($urandom_range(3))
                        0: d = 0;
                        1: d = -1;
                        2: d = -int'($urandom_range(1024, 1));
                        default: d = $urandom_range(1023, display_cfg.max_distance + 1);
                    endcase
                    push_reading(d);
                    made++;
                end
            end else if (roll < 90) begin
                case ($urandom_range(3))
                    0: push_reading(lo);
                    1: push_reading(hi);
                    2: push_reading(hi + 1);
                    default: push_reading(1);
                endcase
                made++;
            end else begin
                push_reading($urandom_range(2047, 0));
                made++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: blank before any good reading, ramp, hold, blink, recovery
        push_reading(-1);
        push_reading(0);
        repeat (6) push_reading(50);
        push_reading(100);
        repeat (6) push_reading(1);
        push_reading(0);
        push_reading(-1024);
        push_reading(1023);
        push_reading(101);
        push_reading(-1);
        push_reading(75);
        push_reading(75);
        push_reading(99);
        push_reading(2);

        // widest range, zones, longest ramp; receiver holds off to back up the block
        apply_settings(1, 400, pbgc_pkg::MODE_ZONES, 500, 15, 15);
        push_reading(400);
        repeat (3) push_reading(1);
        push_reading(80);
        push_reading(160);
        push_reading(240);
        push_reading(320);
        push_reading(399);
        queue_traffic(150);
        hold_off_req = 1'b1;

        // empty range, shown bar above the new strip length
        apply_settings(300, 120, pbgc_pkg::MODE_LINEAR, 37, 1, 1);
        queue_traffic(60);

        // mode three, zero strip, zero ramp, zero error limit
        apply_settings(1, 2, 3, 0, 0, 0);
        queue_traffic(60);

        // field extremes beyond the usual ranges
        apply_settings(0, 511, pbgc_pkg::MODE_SQUARED, 511, 15, 15);
        queue_traffic(80);

        for (int phase = 0; phase < 8; phase++) begin
            random_settings();
            idle_pct = (phase == 0) ? 0 : 31;
            queue_traffic(150);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_display.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pbgc_pkg.sv
rtl/pbgc_muldiv.sv
rtl/pbgc_core.sv
rtl/proximity_bar_graph_controller_unit.sv
verif/proximity_bar_graph_controller_unit_tb.sv
